// ===== rtl/core/rau_pkg.sv =====
// Shared types, codes and the micro-program for the rational arithmetic unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package rau_pkg;

    // Operation selector codes
    localparam logic [2:0] FN_REDUCE = 3'd0;
    localparam logic [2:0] FN_MUL    = 3'd1;
    localparam logic [2:0] FN_DIV    = 3'd2;
    localparam logic [2:0] FN_ADD    = 3'd3;
    localparam logic [2:0] FN_SUB    = 3'd4;
    localparam logic [2:0] FN_GT     = 3'd5;
    localparam logic [2:0] FN_LT     = 3'd6;
    localparam logic [2:0] FN_NONE   = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int PC_W = 5;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_GINIT,
        UOP_GCD,
        UOP_ADDSUB
    } uop_t;

    typedef enum logic [2:0] {
        SRC_N1,
        SRC_D1,
        SRC_N2,
        SRC_D2,
        SRC_G,
        SRC_P,
        SRC_M
    } src_t;

    typedef enum logic [1:0] {
        DST_P,
        DST_M,
        DST_RN,
        DST_RD
    } dst_t;

    // One micro-instruction: mag marks a divisor that is already a magnitude
    typedef struct packed {
        uop_t op;
        src_t a;
        src_t b;
        dst_t dst;
        logic mag;
        logic last;
    } ins_t;

    typedef struct packed {
        logic load;
        logic start;
        logic capture;
        ins_t ins;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic gb_zero;
        logic out_free;
    } sts_t;

    // First micro-instruction of each operation
    function automatic pc_t entry_pc(input logic [2:0] f);
        pc_t pc;
        pc = pc_t'(0);
        case (f) inside
            FN_MUL:                     pc = pc_t'(0);
            FN_DIV:                     pc = pc_t'(2);
            FN_REDUCE:                  pc = pc_t'(4);
            FN_ADD, FN_SUB, FN_GT, FN_LT: pc = pc_t'(8);
            default:                    pc = pc_t'(0);
        endcase
        return pc;
    endfunction

    // Micro-program store
    function automatic ins_t prog(input pc_t pc);
        ins_t i;
        i = '{UOP_ADDSUB, SRC_N1, SRC_N1, DST_RN, 1'b0, 1'b1};
        case (pc)
            // multiply
            pc_t'(0):  i = '{UOP_MUL,    SRC_N1, SRC_N2, DST_RN, 1'b0, 1'b0};
            pc_t'(1):  i = '{UOP_MUL,    SRC_D1, SRC_D2, DST_RD, 1'b0, 1'b1};
            // divide
            pc_t'(2):  i = '{UOP_MUL,    SRC_N1, SRC_D2, DST_RN, 1'b0, 1'b0};
            pc_t'(3):  i = '{UOP_MUL,    SRC_D1, SRC_N2, DST_RD, 1'b0, 1'b1};
            // reduce
            pc_t'(4):  i = '{UOP_GINIT,  SRC_N1, SRC_D1, DST_P,  1'b0, 1'b0};
            pc_t'(5):  i = '{UOP_GCD,    SRC_N1, SRC_N1, DST_P,  1'b0, 1'b0};
            pc_t'(6):  i = '{UOP_DIV,    SRC_N1, SRC_G,  DST_RN, 1'b1, 1'b0};
            pc_t'(7):  i = '{UOP_DIV,    SRC_D1, SRC_G,  DST_RD, 1'b1, 1'b1};
            // add, subtract and compare
            pc_t'(8):  i = '{UOP_MUL,    SRC_D1, SRC_D2, DST_P,  1'b0, 1'b0};
            pc_t'(9):  i = '{UOP_GINIT,  SRC_D1, SRC_D2, DST_P,  1'b0, 1'b0};
            pc_t'(10): i = '{UOP_GCD,    SRC_N1, SRC_N1, DST_P,  1'b0, 1'b0};
            pc_t'(11): i = '{UOP_DIV,    SRC_P,  SRC_G,  DST_P,  1'b1, 1'b0};
            pc_t'(12): i = '{UOP_MUL,    SRC_N1, SRC_P,  DST_M,  1'b0, 1'b0};
            pc_t'(13): i = '{UOP_DIV,    SRC_M,  SRC_D1, DST_RN, 1'b0, 1'b0};
            pc_t'(14): i = '{UOP_MUL,    SRC_N2, SRC_P,  DST_M,  1'b0, 1'b0};
            pc_t'(15): i = '{UOP_DIV,    SRC_M,  SRC_D2, DST_M,  1'b0, 1'b0};
            pc_t'(16): i = '{UOP_ADDSUB, SRC_N1, SRC_N1, DST_RN, 1'b0, 1'b1};
            default:   i = '{UOP_ADDSUB, SRC_N1, SRC_N1, DST_RN, 1'b0, 1'b1};
        endcase
        return i;
    endfunction

endpackage

// ===== rtl/core/rau_if.sv =====
// Valid/ready channel interfaces for operation words and result words.
// Stand-alone; no package needed.
interface rau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               cmp_true;
    logic [1:0]         status;

    modport source (output valid, res_num, res_den, cmp_true, status, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, status, output ready);
endinterface

// ===== rtl/core/rational_arith_unit.sv =====
// Rational arithmetic unit: one operation word in, one result word out.
// Each multiply or divide runs on one shared unit; Euclid takes one such
// division per remainder step (up to about 1.44*WIDTH steps). Reduce and
// the add family also run the gcd loop. One word is worked on at a time.
// Reset (rst_n, asynchronous, active low) empties the output and idles the sequencer.
module rational_arith_unit #(
    parameter int WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    req,
    rau_out_if.source rsp
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req.func),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rau_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .func  (req.func),
        .a_num (req.a_num),
        .a_den (req.a_den),
        .b_num (req.b_num),
        .b_den (req.b_den),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // A word is only taken while the shared unit is free
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !sts.busy)
        else $error("word loaded while unit busy");

    // The output register is only overwritten when free
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> sts.out_free)
        else $error("result captured over a pending word");

    // A launch is never issued into a running unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy && !req.ready)
        else $error("micro-operation launched while busy");
`endif

endmodule

// ===== rtl/core/rau_ctrl.sv =====
// Sequencer for the rational arithmetic unit: walks the micro-program.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2:0]     in_func,
    output logic           in_ready,
    output rau_pkg::cmd_t  cmd,
    input  rau_pkg::sts_t  sts
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    pc_t    pc_reg, pc_next;
    ins_t   ins;

    // Decode state and the current micro-instruction
    always_comb
    begin
        ins         = prog(pc_reg);
        state_next  = state_reg;
        pc_next     = pc_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.ins     = ins;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pc_next    = entry_pc(in_func);
                    state_next = (in_func == FN_NONE) ? S_FIN : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                // Euclid ends once the remainder is zero
                if (ins.op == UOP_GCD && sts.gb_zero)
                    pc_next = pc_reg + pc_t'(1);
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!sts.busy)
                begin
                    if (ins.op == UOP_GCD)
                        state_next = S_ISSUE;
                    else if (ins.last)
                        state_next = S_FIN;
                    else
                    begin
                        pc_next    = pc_reg + pc_t'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

// ===== rtl/core/rau_datapath.sv =====
// Datapath: operand registers, shared shift-add multiplier / restoring divider,
// Euclid registers, adder and the output word register. Depends on rau_pkg, rau_if.
module rau_datapath #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         func,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    input  rau_pkg::cmd_t      cmd,
    output rau_pkg::sts_t      sts,
    rau_out_if.source          rsp
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] word_t;

    logic [2:0]     func_reg;
    word_t          n1_reg, d1_reg, n2_reg, d2_reg;
    word_t          p_reg, m_reg, rn_reg, rd_reg;
    word_t          ga_reg, gb_reg;
    word_t          hi_reg, lo_reg, opb_reg;
    logic           neg_reg;
    logic           busy_reg;
    logic [CW-1:0]  cnt_reg;
    uop_t           kind_reg;
    dst_t           dst_reg;
    logic           zero_reg, ovf_reg;
    logic           out_valid_reg;
    logic signed [31:0] res_num_reg, res_den_reg;
    logic           cmp_reg;
    logic [1:0]     status_reg;

    word_t          va, vb, ua, ub, uy;
    logic           dneg;
    logic [WIDTH:0] msum, dshift, ddiff, as_sum;
    logic           dge;
    word_t          drem, plo, quo;
    logic           last_step;
    logic           wr_en, set_ovf, set_zero;
    dst_t           wr_dst;
    word_t          wr_val;

    function automatic word_t mag(input word_t x);
        return x[WIDTH-1] ? word_t'(-x) : x;
    endfunction

    function automatic word_t take_in(input logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[WIDTH-1:0];
    endfunction

    function automatic logic [31:0] give_out(input word_t w);
        logic signed [63:0] e;
        e = 64'(signed'(w));
        return e[31:0];
    endfunction

    // Magnitude above the signed range for the given sign
    function automatic logic over_lim(input word_t q, input logic neg);
        return neg ? (q[WIDTH-1] && (q[WIDTH-2:0] != '0)) : q[WIDTH-1];
    endfunction

    function automatic word_t pick(input src_t s, input word_t n1, input word_t d1,
                                   input word_t n2, input word_t d2, input word_t g,
                                   input word_t p, input word_t m);
        word_t r;
        r = n1;
        case (s)
            SRC_N1:  r = n1;
            SRC_D1:  r = d1;
            SRC_N2:  r = n2;
            SRC_D2:  r = d2;
            SRC_G:   r = g;
            SRC_P:   r = p;
            SRC_M:   r = m;
            default: r = n1;
        endcase
        return r;
    endfunction

    // Operand select and sign handling
    always_comb
    begin
        va   = pick(cmd.ins.a, n1_reg, d1_reg, n2_reg, d2_reg, ga_reg, p_reg, m_reg);
        vb   = pick(cmd.ins.b, n1_reg, d1_reg, n2_reg, d2_reg, ga_reg, p_reg, m_reg);
        ua   = mag(va);
        ub   = mag(vb);
        uy   = cmd.ins.mag ? vb : ub;
        dneg = va[WIDTH-1] ^ (!cmd.ins.mag & vb[WIDTH-1]);
    end

    // One step of the shared multiply / divide unit, and the add / subtract sum
    always_comb
    begin
        msum      = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opb_reg} : '0);
        dshift    = {hi_reg, lo_reg[WIDTH-1]};
        dge       = dshift >= {1'b0, opb_reg};
        ddiff     = dshift - {1'b0, opb_reg};
        drem      = dge ? ddiff[WIDTH-1:0] : dshift[WIDTH-1:0];
        plo       = {msum[0], lo_reg[WIDTH-1:1]};
        quo       = {lo_reg[WIDTH-2:0], dge};
        last_step = busy_reg && (cnt_reg == CW'(WIDTH - 1));
        as_sum    = (func_reg == FN_ADD)
                  ? {rn_reg[WIDTH-1], rn_reg} + {m_reg[WIDTH-1], m_reg}
                  : {rn_reg[WIDTH-1], rn_reg} - {m_reg[WIDTH-1], m_reg};
    end

    // Result write port
    always_comb
    begin
        wr_en    = 1'b0;
        wr_dst   = dst_reg;
        wr_val   = '0;
        set_ovf  = 1'b0;
        set_zero = 1'b0;
        if (last_step && kind_reg == UOP_MUL)
        begin
            wr_en   = 1'b1;
            wr_val  = neg_reg ? word_t'(-plo) : plo;
            set_ovf = (msum[WIDTH:1] != '0) || over_lim(plo, neg_reg);
        end
        else if (last_step && kind_reg == UOP_DIV)
        begin
            wr_en   = 1'b1;
            wr_val  = neg_reg ? word_t'(-quo) : quo;
            set_ovf = over_lim(quo, neg_reg);
        end
        else if (cmd.start && cmd.ins.op == UOP_DIV && uy == '0)
        begin
            wr_en    = 1'b1;
            wr_dst   = cmd.ins.dst;
            set_zero = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start && (cmd.ins.op == UOP_MUL || cmd.ins.op == UOP_GCD
                              || (cmd.ins.op == UOP_DIV && uy != '0)))
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
            if (cmd.capture)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            n1_reg   <= take_in(a_num);
            d1_reg   <= take_in(a_den);
            n2_reg   <= take_in(b_num);
            d2_reg   <= take_in(b_den);
            rn_reg   <= '0;
            rd_reg   <= '0;
            zero_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end

        // Launch a micro-operation
        if (cmd.start)
        begin
            kind_reg <= cmd.ins.op;
            dst_reg  <= cmd.ins.dst;
            case (cmd.ins.op)
                UOP_MUL:
                begin
                    lo_reg  <= ub;
                    hi_reg  <= '0;
                    opb_reg <= ua;
                    neg_reg <= va[WIDTH-1] ^ vb[WIDTH-1];
                end
                UOP_DIV:
                begin
                    lo_reg  <= ua;
                    hi_reg  <= '0;
                    opb_reg <= uy;
                    neg_reg <= dneg;
                end
                UOP_GINIT:
                begin
                    ga_reg <= ua;
                    gb_reg <= ub;
                end
                UOP_GCD:
                begin
                    lo_reg  <= ga_reg;
                    hi_reg  <= '0;
                    opb_reg <= gb_reg;
                    neg_reg <= 1'b0;
                end
                UOP_ADDSUB:
                begin
                    rn_reg <= as_sum[WIDTH-1:0];
                    rd_reg <= p_reg;
                    if (as_sum[WIDTH] ^ as_sum[WIDTH-1])
                        ovf_reg <= 1'b1;
                end
                default:
                begin
                    lo_reg <= lo_reg;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (kind_reg == UOP_MUL)
            begin
                hi_reg <= msum[WIDTH:1];
                lo_reg <= plo;
            end
            else
            begin
                hi_reg <= drem;
                lo_reg <= quo;
            end
            // Euclid: shift the pair down by one remainder
            if (last_step && kind_reg == UOP_GCD)
            begin
                ga_reg <= gb_reg;
                gb_reg <= drem;
            end
        end

        if (wr_en)
        begin
            case (wr_dst)
                DST_P:   p_reg  <= wr_val;
                DST_M:   m_reg  <= wr_val;
                DST_RN:  rn_reg <= wr_val;
                DST_RD:  rd_reg <= wr_val;
                default: p_reg  <= wr_val;
            endcase
        end
        if (set_ovf)
            ovf_reg <= 1'b1;
        if (set_zero)
            zero_reg <= 1'b1;

        // Hold the finished word for the output side
        if (cmd.capture)
        begin
            res_num_reg <= give_out(rn_reg);
            res_den_reg <= give_out(rd_reg);
            if (func_reg == FN_GT)
                cmp_reg <= !rn_reg[WIDTH-1] && (rn_reg != '0);
            else if (func_reg == FN_LT)
                cmp_reg <= rn_reg[WIDTH-1];
            else
                cmp_reg <= 1'b0;
            if (zero_reg)
                status_reg <= ST_ZERO;
            else if (ovf_reg)
                status_reg <= ST_OVF;
            else
                status_reg <= ST_OK;
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.gb_zero  = (gb_reg == '0);
    assign sts.out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.res_num  = res_num_reg;
    assign rsp.res_den  = res_den_reg;
    assign rsp.cmp_true = cmp_reg;
    assign rsp.status   = status_reg;

endmodule
